// File: hw/rtl/four_level_page_table_walker_core_macros.svh
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core_macros.svh
// Assertion macros used by the page table walker core.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("page table walker assertion failed");

// Next-cycle implication.
`define PTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("page table walker assertion failed");

`else

`define PTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants of the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

	localparam int VA_W        = 48;
	localparam int WIDX_W      = 12;
	localparam int DATA_W      = 64;
	localparam int ROOT_W      = 15;
	localparam int LVL_IDX_W   = 9;
	localparam int PFN_W       = 40;
	// Word address built from a 40-bit frame number and a 9-bit table index.
	localparam int WORD_ADDR_W = PFN_W + LVL_IDX_W;
	localparam int LARGE_BIT   = 7;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_XLATE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		WS_IDLE,
		WS_WALK,
		WS_DONE
	} walk_state_t;

	localparam logic [1:0] LVL_ROOT   = 2'd0;
	localparam logic [1:0] LVL_THIRD  = 2'd1;
	localparam logic [1:0] LVL_SECOND = 2'd2;
	localparam logic [1:0] LVL_LAST   = 2'd3;

	typedef struct packed {
		logic busy;
		logic walking;
	} ptw_stat_t;

endpackage

// File: hw/rtl/ptw_if.sv
// ----------------------------------------------------------------------------
// ptw_if
// Valid/ready channels for requests into and responses out of the walker.
// ----------------------------------------------------------------------------
interface ptw_req_if;
	import ptw_pkg::*;

	logic                valid;
	logic                ready;
	action_t             action;
	logic [VA_W-1:0]     vaddr;
	logic [WIDX_W-1:0]   word_index;
	logic [DATA_W-1:0]   word_data;

	modport source (output valid, output action, output vaddr, output word_index,
		output word_data, input ready);
	modport sink (input valid, input action, input vaddr, input word_index,
		input word_data, output ready);
endinterface

interface ptw_rsp_if;
	import ptw_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	logic [DATA_W-1:0]   paddr;
	logic                large_page;

	modport source (output valid, output status, output paddr, output large_page,
		input ready);
	modport sink (input valid, input status, input paddr, input large_page,
		output ready);
endinterface

// File: hw/rtl/ptw_mem.sv
// ----------------------------------------------------------------------------
// ptw_mem
// Table word memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptw_mem #(
	parameter int MEM_WORDS = 4096
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(MEM_WORDS)-1:0]     wr_addr,
	input  logic [ptw_pkg::DATA_W-1:0]       wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(MEM_WORDS)-1:0]     rd_addr,
	output logic [ptw_pkg::DATA_W-1:0]       rd_data
);
	import ptw_pkg::*;

	logic [DATA_W-1:0] mem [MEM_WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/ptw_walk.sv
// ----------------------------------------------------------------------------
// ptw_walk
// Walk sequencer: takes requests, drives the table memory one level per
// cycle and holds the result in an output register.
// ----------------------------------------------------------------------------
module ptw_walk #(
	parameter int MEM_WORDS = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ptw_pkg::ROOT_W-1:0]       root_addr,
	ptw_req_if.sink                          req,
	ptw_rsp_if.source                        rsp,
	output logic                             mem_wr_en,
	output logic [$clog2(MEM_WORDS)-1:0]     mem_wr_addr,
	output logic [ptw_pkg::DATA_W-1:0]       mem_wr_data,
	output logic                             mem_rd_en,
	output logic [$clog2(MEM_WORDS)-1:0]     mem_rd_addr,
	input  logic [ptw_pkg::DATA_W-1:0]       mem_rd_data,
	output ptw_pkg::ptw_stat_t               stat
);
	import ptw_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [WORD_ADDR_W-1:0] LIMIT = WORD_ADDR_W'(MEM_WORDS);

	walk_state_t state_q, state_d;
	logic [1:0]             level_q;
	logic                   level_clr, level_inc;
	logic [VA_W-1:0]        va_q;
	logic                   va_ld;

	status_t                res_status_q, res_status_d;
	logic [DATA_W-1:0]      res_paddr_q, res_paddr_d;
	logic                   res_large_q, res_large_d;
	logic                   res_ld;

	logic                   out_valid_q;
	logic                   out_ld;

	logic [WORD_ADDR_W-1:0] widx_ext;
	logic [WORD_ADDR_W-1:0] root_word;
	logic [WORD_ADDR_W-1:0] next_word;
	logic [PFN_W-1:0]       next_pfn;
	logic [LVL_IDX_W-1:0]   next_idx;

	assign widx_ext  = WORD_ADDR_W'(req.word_index);
	// The root table is 4 KiB aligned, so its word base is bits 14:12 above the index.
	assign root_word = WORD_ADDR_W'({root_addr[ROOT_W-1:12], req.vaddr[47:39]});
	assign next_pfn  = mem_rd_data[51:12];
	assign next_word = {next_pfn, next_idx};

	always_comb begin
		unique case (level_q)
			LVL_ROOT:   next_idx = va_q[38:30];
			LVL_THIRD:  next_idx = va_q[29:21];
			default:    next_idx = va_q[20:12];
		endcase
	end

	assign mem_wr_addr = widx_ext[AW-1:0];
	assign mem_wr_data = req.word_data;

	always_comb begin
		state_d      = state_q;
		req.ready    = 1'b0;
		mem_wr_en    = 1'b0;
		mem_rd_en    = 1'b0;
		mem_rd_addr  = root_word[AW-1:0];
		level_clr    = 1'b0;
		level_inc    = 1'b0;
		va_ld        = 1'b0;
		res_ld       = 1'b0;
		res_status_d = ST_OK;
		res_paddr_d  = '0;
		res_large_d  = 1'b0;
		out_ld       = 1'b0;

		unique case (state_q)
			WS_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.action == ACT_WRITE) begin
						// Writes beyond the memory are dropped but still answered.
						mem_wr_en = (widx_ext < LIMIT);
						res_ld    = 1'b1;
						state_d   = WS_DONE;
					end else if (root_word < LIMIT) begin
						mem_rd_en = 1'b1;
						level_clr = 1'b1;
						va_ld     = 1'b1;
						state_d   = WS_WALK;
					end else begin
						res_ld       = 1'b1;
						res_status_d = ST_RANGE;
						state_d      = WS_DONE;
					end
				end
			end
			WS_WALK: begin
				mem_rd_addr = next_word[AW-1:0];
				priority if (level_q == LVL_LAST) begin
					res_ld      = 1'b1;
					res_paddr_d = DATA_W'({next_pfn, va_q[11:0]});
					state_d     = WS_DONE;
				end else if (level_q == LVL_SECOND && mem_rd_data[LARGE_BIT]) begin
					res_ld      = 1'b1;
					res_paddr_d = DATA_W'({mem_rd_data[51:21], va_q[20:0]});
					res_large_d = 1'b1;
					state_d     = WS_DONE;
				end else if (next_pfn == '0) begin
					res_ld       = 1'b1;
					res_status_d = ST_NULL;
					state_d      = WS_DONE;
				end else if (next_word >= LIMIT) begin
					res_ld       = 1'b1;
					res_status_d = ST_RANGE;
					state_d      = WS_DONE;
				end else begin
					mem_rd_en = 1'b1;
					level_inc = 1'b1;
				end
			end
			WS_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_ld  = 1'b1;
					state_d = WS_IDLE;
				end
			end
			default: begin
				state_d = WS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= WS_IDLE;
			level_q     <= LVL_ROOT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (level_clr) begin
				level_q <= LVL_ROOT;
			end else if (level_inc) begin
				level_q <= level_q + 2'd1;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (va_ld) begin
			va_q <= req.vaddr;
		end
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_paddr_q  <= res_paddr_d;
			res_large_q  <= res_large_d;
		end
		if (out_ld) begin
			rsp.status     <= res_status_q;
			rsp.paddr      <= res_paddr_q;
			rsp.large_page <= res_large_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign stat.busy    = (state_q != WS_IDLE);
	assign stat.walking = (state_q == WS_WALK);

endmodule

// File: hw/rtl/four_level_page_table_walker_core.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core
// Four-level page table walker over a local table word memory.
// ----------------------------------------------------------------------------
// Each request transaction either writes one 64-bit table word or translates
// a 48-bit virtual address, and yields exactly one response transaction. A
// translation reads one table level per cycle through the read port of the
// table memory and stops after the last level, at a 2 MiB page, or early on
// a zero pointer or an out-of-range table. A finished response waits in the
// output register while the next request is taken.
// The table memory is not cleared: a walk must only touch words written before.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_core_macros.svh"

module four_level_page_table_walker_core #(
	parameter int MEM_WORDS = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [ptw_pkg::ROOT_W-1:0]   cfg_wr_data,
	ptw_req_if.sink                      req,
	ptw_rsp_if.source                    rsp
);
	import ptw_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);

	logic [ROOT_W-1:0]  root_addr_q;
	logic               mem_wr_en;
	logic [AW-1:0]      mem_wr_addr;
	logic [DATA_W-1:0]  mem_wr_data;
	logic               mem_rd_en;
	logic [AW-1:0]      mem_rd_addr;
	logic [DATA_W-1:0]  mem_rd_data;
	ptw_stat_t          stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_addr_q <= '0;
		end else if (cfg_wr_en) begin
			root_addr_q <= cfg_wr_data;
		end
	end

	ptw_walk #(
		.MEM_WORDS (MEM_WORDS)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.root_addr   (root_addr_q),
		.req         (req),
		.rsp         (rsp),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.stat        (stat)
	);

	ptw_mem #(
		.MEM_WORDS (MEM_WORDS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// A response is only loaded from the busy completion state.
	`PTW_ASSERT_IMP(a_rsp_from_busy, clk, arst_n, $rose(rsp.valid), $past(stat.busy))
	`PTW_ASSERT_NXT(a_accept_busy, clk, arst_n, req.valid && req.ready, stat.busy)
	`PTW_ASSERT_IMP(a_large_ok, clk, arst_n, rsp.valid && rsp.large_page, rsp.status == ST_OK)
	`PTW_ASSERT_IMP(a_fault_zero, clk, arst_n, rsp.valid && rsp.status != ST_OK, rsp.paddr == '0 && !rsp.large_page)
	`PTW_ASSERT_IMP(a_walk_no_take, clk, arst_n, stat.walking, !req.ready && !mem_wr_en)

endmodule

// File: test/four_level_page_table_walker_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core_test
// Self-checking testbench for the four-level page table walker.
// ----------------------------------------------------------------------------
// A short table of directed transactions covers the extremes of the entry
// fields, the 2 MiB page, zero root and second-level pointers and tables outside the
// word memory. Random walks follow. The stimulus fills in any table word that
// a walk would read before that word has been written, so that only written
// words are ever read. Responses are compared field by field with a row's
// typed result or a local walk over a shadow of the table memory. The phases
// change the root table register and the valid/ready idling, and one phase
// holds the response side off long enough for the block to fill and stall.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_core_test;
	import ptw_pkg::*;

	localparam int TABLE_WORDS      = 4096;
	localparam int PHASE_COUNT      = 8;
	localparam int PHASE_ITEMS      = 250;
	localparam int DIRECTED_COUNT   = 26;
	localparam int HOLD_CYCLES      = 400;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int MAX_REPORTED     = 10;
	localparam logic [63:0] FRAME_4K = 64'h000F_FFFF_FFFF_F000;
	localparam logic [63:0] FRAME_2M = 64'h000F_FFFF_FFE0_0000;

	typedef struct packed {
		status_t     st;
		logic [63:0] pa;
		logic        lg;
	} xlate_result_t;

	typedef struct packed {
		action_t       act;
		logic [47:0]   va;
		logic [11:0]   wi;
		logic [63:0]   wd;
		logic          typed;
		xlate_result_t res;
	} walk_case_t;

	// Rows with typed set carry their expected response; the rest are
	// checked against the local walk.
	walk_case_t directed_cases [DIRECTED_COUNT] = '{
		'{ACT_WRITE, 48'h0, 12'd0, 64'h0, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_XLATE, 48'h0, 12'd0, 64'h0, 1'b1, '{ST_NULL, 64'h0, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_XLATE, 48'h0, 12'd0, 64'h0, 1'b1, '{ST_RANGE, 64'h0, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd511, 64'hFFF0_0000_0000_1FFF, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd1023, 64'h8000_0000_0000_2067, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd1535, 64'h0000_0000_0000_3003, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd2047, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_XLATE, 48'hFFFF_FFFF_FFFF, 12'd0, 64'h0, 1'b1,
			'{ST_OK, 64'h000F_FFFF_FFFF_FFFF, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd2047, 64'h0, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_XLATE, 48'hFFFF_FFFF_FFFF, 12'd0, 64'h0, 1'b1, '{ST_OK, 64'hFFF, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd1535, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_XLATE, 48'hFFFF_FFFF_FFFF, 12'd0, 64'h0, 1'b1,
			'{ST_OK, 64'h000F_FFFF_FFFF_FFFF, 1'b1}},
		'{ACT_XLATE, 48'hFFFF_FFE1_2345, 12'd0, 64'h0, 1'b0, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd1535, 64'h0000_0000_0000_0083, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_XLATE, 48'hFFFF_FFFF_FFFF, 12'd0, 64'h0, 1'b1, '{ST_OK, 64'h1F_FFFF, 1'b1}},
		'{ACT_WRITE, 48'h0, 12'd1535, 64'h0000_0000_0000_0003, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_XLATE, 48'hFFFF_FFFF_FFFF, 12'd0, 64'h0, 1'b1, '{ST_NULL, 64'h0, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd1535, 64'h0000_0000_0000_3003, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd1023, 64'h0008_0000_0000_0000, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_XLATE, 48'hFFFF_FFFF_FFFF, 12'd0, 64'h0, 1'b1, '{ST_RANGE, 64'h0, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd1023, 64'h0000_0000_0000_2067, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd2047, 64'h0123_4567_89AB_CDEF, 1'b0, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_XLATE, 48'hFFFF_FFFF_F000, 12'd0, 64'h0, 1'b0, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_WRITE, 48'h0, 12'd256, 64'h0, 1'b1, '{ST_OK, 64'h0, 1'b0}},
		'{ACT_XLATE, 48'h8000_0000_0000, 12'd0, 64'h0, 1'b1, '{ST_NULL, 64'h0, 1'b0}}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [ROOT_W-1:0]   cfg_wr_data;

	ptw_req_if req_ch ();
	ptw_rsp_if rsp_ch ();

	four_level_page_table_walker_core #(
		.MEM_WORDS(TABLE_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow of the block's state.
	logic [63:0]         table_words [TABLE_WORDS];
	bit                  word_written [TABLE_WORDS];
	logic [ROOT_W-1:0]   root_reg = '0;

	xlate_result_t       pending_results [$];
	int                  mismatch_count = 0;
	int                  quiet_cycles = 0;
	int                  phase_items = 0;
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	bit                  hold_request = 1'b0;
	int                  hold_left = 0;

	// Side information that travels with the request being offered.
	logic                drv_typed = 1'b0;
	xlate_result_t       drv_typed_res = '0;

	always #4 clk = ~clk;

	// Walks the shadow tables. Returns 0, with the word and its level, when
	// the walk would read a word that has not been written yet.
	function automatic bit walk_tables(input logic [47:0] va, output status_t st,
		output logic [63:0] pa, output logic lg, output int miss_word,
		output logic [1:0] miss_lvl);
		logic [63:0] tbl;
		logic [63:0] entry;
		logic [63:0] word;
		bit          done;
		int          lvl;
		st = ST_OK;
		pa = '0;
		lg = 1'b0;
		miss_word = -1;
		miss_lvl = LVL_ROOT;
		done = 1'b0;
		tbl = {49'b0, root_reg[14:12], 12'b0};
		for (lvl = 0; lvl < 4 && !done; lvl++) begin
			word = (tbl >> 3) + 64'(va[39 - 9 * lvl +: 9]);
			if (word >= TABLE_WORDS) begin
				st = ST_RANGE;
				done = 1'b1;
			end else if (!word_written[word[11:0]]) begin
				miss_word = int'(word);
				miss_lvl = 2'(lvl);
				return 1'b0;
			end else begin
				entry = table_words[word[11:0]];
				if (lvl == LVL_LAST) begin
					pa = (entry & FRAME_4K) + {52'b0, va[11:0]};
					done = 1'b1;
				end else if (lvl == LVL_SECOND && entry[LARGE_BIT]) begin
					pa = (entry & FRAME_2M) + {43'b0, va[20:0]};
					lg = 1'b1;
					done = 1'b1;
				end else begin
					tbl = entry & FRAME_4K;
					if (tbl == 0) begin
						st = ST_NULL;
						done = 1'b1;
					end
				end
			end
		end
		if (st != ST_OK) begin
			pa = '0;
			lg = 1'b0;
		end
		return 1'b1;
	endfunction

	// Indices favour a few values so that later walks reuse written tables.
	function automatic logic [8:0] pick_index();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return 9'($urandom_range(511));
		case (r % 4)
			0: return 9'd0;
			1: return 9'd511;
			2: return 9'd1;
			default: return 9'd256;
		endcase
	endfunction

	// A table entry for the given level: a random frame for a leaf, else
	// mostly a pointer to a table at 4 KiB pages 1 to 7, sometimes zero or far away.
	function automatic logic [63:0] make_entry(input logic [1:0] lvl);
		logic [63:0] e;
		int          r;
		e = {$urandom, $urandom};
		e[51:12] = '0;
		r = $urandom_range(99);
		if (lvl == LVL_LAST || (lvl == LVL_SECOND && e[LARGE_BIT])) begin
			e[51:12] = 40'({$urandom, $urandom});
		end else if (r < 7) begin
			e[51:12] = '0;
		end else if (r < 13) begin
			e[51:12] = 40'({$urandom, $urandom});
			e[$urandom_range(51, 15)] = 1'b1;
		end else begin
			e[14:12] = 3'($urandom_range(7, 1));
		end
		return e;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance,
	// with valid still high so that the next call can continue without a gap.
	task automatic send_item(input action_t act, input logic [47:0] va,
		input logic [11:0] wi, input logic [63:0] wd, input logic typed,
		input xlate_result_t typed_res);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.vaddr <= va;
		req_ch.word_index <= wi;
		req_ch.word_data <= wd;
		drv_typed = typed;
		drv_typed_res = typed_res;
		do
			@(posedge clk);
		while (!req_ch.ready);
		phase_items++;
		@(negedge clk);
	endtask

	// Writes whatever table words the walk still lacks, then translates.
	task automatic send_walk(input bit any_va);
		logic [47:0] va;
		status_t     st;
		logic [63:0] pa;
		logic        lg;
		int          mw;
		logic [1:0]  ml;
		va = any_va ? 48'({$urandom, $urandom})
			: {pick_index(), pick_index(), pick_index(), pick_index(), 12'($urandom)};
		while (!walk_tables(va, st, pa, lg, mw, ml))
			send_item(ACT_WRITE, 48'({$urandom, $urandom}), 12'(mw), make_entry(ml),
				1'b0, '0);
		send_item(ACT_XLATE, va, 12'($urandom), {$urandom, $urandom}, 1'b0, '0);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_root_table(input logic [ROOT_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic note_mismatch(input string what, input xlate_result_t want,
		input xlate_result_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTED)
			$display("mismatch (%s): expected status %0d paddr %h large %0b, got status %0d paddr %h large %0b",
				what, want.st, want.pa, want.lg, got.st, got.pa, got.lg);
	endtask

	// Response side: random stalls, or a long hold-off when one is asked for.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Checks each response transaction, then predicts for each request.
	always @(posedge clk) begin
		xlate_result_t want;
		xlate_result_t got;
		xlate_result_t pred;
		int            mw;
		logic [1:0]    ml;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.status, rsp_ch.paddr, rsp_ch.large_page};
				if (pending_results.size() == 0) begin
					note_mismatch("response with nothing pending", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (got.st !== want.st)
						note_mismatch("status", want, got);
					else if (got.pa !== want.pa)
						note_mismatch("paddr", want, got);
					else if (got.lg !== want.lg)
						note_mismatch("large_page", want, got);
				end
			end
			if (cfg_wr_en)
				root_reg = cfg_wr_data;
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.action == ACT_WRITE) begin
					table_words[req_ch.word_index] = req_ch.word_data;
					word_written[req_ch.word_index] = 1'b1;
					pred = '{ST_OK, 64'h0, 1'b0};
				end else begin
					void'(walk_tables(req_ch.vaddr, pred.st, pred.pa, pred.lg, mw, ml));
				end
				pending_results.push_back(drv_typed ? drv_typed_res : pred);
			end
		end
	end

	// Ends the run when no transaction has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("four_level_page_table_walker_core_test: FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [ROOT_W-1:0] roots [PHASE_COUNT];
		logic [ROOT_W-1:0] root_value;
		int                i;
		int                ph;
		int                r;
		roots = '{15'h7FFF, 15'h0000, 15'h1ABC, 15'h3000, 15'h0, 15'h0, 15'h6FFF, 15'h0};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_WRITE;
		req_ch.vaddr = '0;
		req_ch.word_index = '0;
		req_ch.word_data = '0;
		rsp_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The root register keeps its reset value for the directed rows.
		for (i = 0; i < DIRECTED_COUNT; i++)
			send_item(directed_cases[i].act, directed_cases[i].va, directed_cases[i].wi,
				directed_cases[i].wd, directed_cases[i].typed, directed_cases[i].res);

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 58;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 58;
				end
				default: begin
					send_idle_pct = 17;
					recv_stall_pct = 17;
				end
			endcase
			root_value = (ph == 4 || ph == 5 || ph == 7) ? 15'($urandom_range(32767))
				: roots[ph];
			set_root_table(root_value);
			// With the sender never idle, a long hold-off fills the block.
			if (ph == 4)
				hold_request = 1'b1;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 10)
					send_item(ACT_WRITE, 48'({$urandom, $urandom}), 12'($urandom),
						{$urandom, $urandom}, 1'b0, '0);
				else
					send_walk(r < 18);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("four_level_page_table_walker_core_test: PASS");
		else
			$display("four_level_page_table_walker_core_test: FAIL");
		$finish;
	end

endmodule
